// File: rtl/previous_greater_span_defines.svh
// assertion helpers for the previous greater span block
`ifndef PREVIOUS_GREATER_SPAN_DEFINES_SVH
`define PREVIOUS_GREATER_SPAN_DEFINES_SVH

`ifndef SYNTHESIS
`define PGS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define PGS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PGS_ASSERT_IMP(lbl, ante, cons, msg)
`define PGS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/pgs_pkg.sv
package pgs_pkg;

  localparam int DEPTH  = 1024;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int H_W    = 32;
  localparam int POS_W  = 11;
  localparam int SPAN_W = 10;
  localparam int TGT_W  = 10;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [0:0] REG_TARGET_SPAN = 1'b0;

  typedef struct packed {
    logic signed [H_W-1:0] height;
    logic [SPAN_W-1:0]     span;
  } pgs_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_FINISH = 3'b100
  } pgs_state_e;

endpackage

// File: rtl/pgs_if.sv
interface pgs_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [pgs_pkg::H_W-1:0]   height;
  logic                             restart;

  modport source (output valid, output height, output restart, input ready);
  modport sink (input valid, input height, input restart, output ready);
endinterface

interface pgs_out_if;
  logic                        valid;
  logic                        ready;
  logic [pgs_pkg::POS_W-1:0]   position;
  logic [pgs_pkg::SPAN_W-1:0]  span;
  logic                        is_match;
  logic                        overflow;

  modport source (output valid, output position, output span, output is_match,
                  output overflow, input ready);
  modport sink (input valid, input position, input span, input is_match,
                input overflow, output ready);
endinterface

// File: rtl/previous_greater_span.sv
// a request that needs no search (restart, first element or full store) goes from IDLE
// to FINISH; otherwise it goes to SEARCH, which reads the span store once per chain-walk jump
// throughput: a new request is taken only in IDLE, once the last one has finished; the walk is
// set by the single read port of the height/span memory, one jump per cycle
// reset: element count and target_span cleared, store contents left undefined
`include "previous_greater_span_defines.svh"

module previous_greater_span (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pgs_in_if.sink                        in_req,
  pgs_out_if.source                     out_res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pgs_pkg::PADDR_W-1:0]   paddr,
  input  logic [pgs_pkg::PDATA_W-1:0]   pwdata,
  output logic [pgs_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int IW = pgs_pkg::IDX_W;
  localparam int CW = pgs_pkg::CNT_W;

  pgs_pkg::pgs_state_e state_q, state_d;

  logic [CW-1:0]                    count_q;
  logic [pgs_pkg::TGT_W-1:0]        target_q;
  logic signed [pgs_pkg::H_W-1:0]   h_q;
  logic [IW-1:0]                    i_q;
  logic [IW-1:0]                    j_q;
  logic [pgs_pkg::SPAN_W-1:0]       span_q;
  logic                             ovf_q;

  logic                             out_valid_q;
  logic [pgs_pkg::POS_W-1:0]        out_pos_q;
  logic [pgs_pkg::SPAN_W-1:0]       out_span_q;
  logic                             out_match_q;
  logic                             out_ovf_q;

  pgs_pkg::pgs_entry_t              mem [pgs_pkg::DEPTH];
  pgs_pkg::pgs_entry_t              rdata_q;
  pgs_pkg::pgs_entry_t              wdata;
  logic                             rd_en;
  logic [IW-1:0]                    rd_addr;
  logic                             wr_en;

  logic                             accept;
  logic                             full;
  logic                             need_search;
  logic [IW+1:0]                    j_next;
  logic                             greater;
  logic                             stop;
  logic [pgs_pkg::SPAN_W-1:0]       span_stop;
  logic                             out_free;
  logic                             load;
  logic [pgs_pkg::SPAN_W-1:0]       load_span;
  logic                             load_ovf;
  logic                             cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == pgs_pkg::REG_TARGET_SPAN)
                  ? pgs_pkg::PDATA_W'(target_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_wr && paddr[2] == pgs_pkg::REG_TARGET_SPAN) begin
      target_q <= pwdata[pgs_pkg::TGT_W-1:0];
    end
  end

  // request decode
  assign in_req.ready = (state_q == pgs_pkg::ST_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign full         = !in_req.restart && (count_q >= CW'(pgs_pkg::DEPTH));
  assign need_search  = !in_req.restart && (count_q != '0) && !full;

  // chain walk: jump back over the stored span while the new height is greater
  assign greater   = h_q > rdata_q.height;
  assign j_next    = {2'b00, j_q} - {2'b00, rdata_q.span} - (IW+2)'(1);
  assign stop      = (state_q == pgs_pkg::ST_SEARCH) && !(greater && !j_next[IW+1]);
  assign span_stop = greater ? pgs_pkg::SPAN_W'(i_q)
                             : pgs_pkg::SPAN_W'(i_q - j_q - IW'(1));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = j_next[IW-1:0];
    if (accept && need_search) begin
      rd_en   = 1'b1;
      rd_addr = count_q[IW-1:0] - IW'(1);
    end else if (state_q == pgs_pkg::ST_SEARCH && !stop) begin
      rd_en = 1'b1;
    end
  end

  assign wr_en       = stop || (state_q == pgs_pkg::ST_FINISH && !ovf_q);
  assign wdata.height = h_q;
  assign wdata.span   = stop ? span_stop : span_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[i_q] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // result staging
  assign out_free  = !out_valid_q || out_res.ready;
  assign load      = (stop || state_q == pgs_pkg::ST_FINISH) && out_free;
  assign load_span = stop ? span_stop : span_q;
  assign load_ovf  = stop ? 1'b0 : ovf_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      pgs_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = need_search ? pgs_pkg::ST_SEARCH : pgs_pkg::ST_FINISH;
        end
      end
      pgs_pkg::ST_SEARCH: begin
        if (stop) begin
          state_d = out_free ? pgs_pkg::ST_IDLE : pgs_pkg::ST_FINISH;
        end
      end
      pgs_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = pgs_pkg::ST_IDLE;
        end
      end
      default: state_d = pgs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pgs_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && !full) begin
        count_q <= (in_req.restart ? CW'(0) : count_q) + CW'(1);
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      h_q    <= in_req.height;
      i_q    <= in_req.restart ? IW'(0) : count_q[IW-1:0];
      j_q    <= count_q[IW-1:0] - IW'(1);
      span_q <= '0;
      ovf_q  <= full;
    end else if (state_q == pgs_pkg::ST_SEARCH) begin
      j_q    <= j_next[IW-1:0];
      span_q <= span_stop;
      ovf_q  <= 1'b0;
    end
    if (load) begin
      out_pos_q   <= load_ovf ? '0 : pgs_pkg::POS_W'({1'b0, i_q} + (IW+1)'(1));
      out_span_q  <= load_ovf ? '0 : load_span;
      out_match_q <= !load_ovf && (load_span == target_q);
      out_ovf_q   <= load_ovf;
    end
  end

  assign out_res.valid    = out_valid_q;
  assign out_res.position = out_pos_q;
  assign out_res.span     = out_span_q;
  assign out_res.is_match = out_match_q;
  assign out_res.overflow = out_ovf_q;

  `PGS_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(pgs_pkg::DEPTH), "count beyond depth")
  `PGS_ASSERT_NXT(a_full_goes_finish, accept && full, state_q == pgs_pkg::ST_FINISH && ovf_q, "overflow request not finished directly")
  `PGS_ASSERT_IMP(a_span_le_index, load && !load_ovf, load_span <= pgs_pkg::SPAN_W'(i_q), "span exceeds element index")
  `PGS_ASSERT_IMP(a_ovf_fields_zero, out_valid_q && out_ovf_q, out_pos_q == '0 && out_span_q == '0 && !out_match_q, "overflow result carries data")

endmodule
